@@ design/lrsl_pkg.sv @@
// ----------------------------------------------------------------------------
// lrsl_pkg
// Shared types, constants and address tables for the seconds ring level block.
// ----------------------------------------------------------------------------
package lrsl_pkg;

    // Ring geometry
    localparam int RING_POSITIONS = 60;
    localparam int TICK_COUNT     = 12;
    localparam int TICK_SPACING   = RING_POSITIONS / TICK_COUNT;
    localparam int RING_LAST      = RING_POSITIONS - 1;

    // floor(pos / TICK_SPACING) as (pos * TICK_RECIP) >> TICK_RECIP_SHIFT, exact below 64
    localparam int TICK_RECIP_SHIFT = 6;
    localparam int TICK_RECIP       = ((1 << TICK_RECIP_SHIFT) + TICK_SPACING - 1) / TICK_SPACING;

    // floor(r / 15) as (r * DIV15_RECIP) >> DIV15_SHIFT, exact for r below 1499
    localparam int DIV15_SHIFT = 14;
    localparam int DIV15_RECIP = 1093;

    // Brightness codes (2048 is full scale)
    localparam logic [11:0] LEVEL_FULL = 12'd2048;
    localparam logic [11:0] LEVEL_DIM  = 12'd512;
    localparam logic [11:0] LEVEL_OFF  = 12'd0;

    // Register indexes on the APB port
    localparam logic REG_TICK_MODE = 1'b0;
    localparam logic REG_DOT_STYLE = 1'b1;

    typedef enum logic [1:0] {
        TICK_TRACK = 2'd0,
        TICK_OFF   = 2'd1,
        TICK_ON    = 2'd2,
        TICK_DIM   = 2'd3
    } tick_sel_t;

    typedef enum logic [2:0] {
        SEC_FILL   = 3'd0,
        SEC_SINGLE = 3'd1,
        SEC_SHORT  = 3'd2,
        SEC_MEDIUM = 3'd3,
        SEC_LONG   = 3'd4
    } dot_style_t;

    // Configuration handed from the register file to the datapath
    typedef struct packed {
        tick_sel_t  tick_mode;
        dot_style_t dot_style;
    } cfg_t;

    // One result transaction
    typedef struct packed {
        logic [7:0]  second_led;
        logic [7:0]  pair_led;
        logic [11:0] second_level;
        logic [7:0]  tick_led;
        logic [11:0] tick_level;
        logic        tick_valid;
    } res_t;

    localparam logic [7:0] TICK_ADDR [0:TICK_COUNT-1] = '{
        8'd235, 8'd226, 8'd26, 8'd10, 8'd90, 8'd106,
        8'd111, 8'd101, 8'd153, 8'd169, 8'd218, 8'd234
    };

    // Dot pairs, two entries per position; track mode swaps in the hour LED
    localparam logic [7:0] DOT_TRACK [0:2*RING_POSITIONS-1] = '{
        8'd236, 8'd235, 8'd231, 8'd231, 8'd230, 8'd230, 8'd229, 8'd229,
        8'd228, 8'd228, 8'd227, 8'd226, 8'd225, 8'd225, 8'd248, 8'd248,
        8'd250, 8'd250, 8'd249, 8'd249, 8'd24,  8'd26,  8'd25,  8'd25,
        8'd40,  8'd40,  8'd42,  8'd42,  8'd41,  8'd41,  8'd8,   8'd10,
        8'd9,   8'd9,   8'd56,  8'd56,  8'd58,  8'd58,  8'd57,  8'd57,
        8'd88,  8'd90,  8'd89,  8'd89,  8'd72,  8'd72,  8'd74,  8'd74,
        8'd104, 8'd104, 8'd105, 8'd106, 8'd107, 8'd107, 8'd108, 8'd108,
        8'd109, 8'd109, 8'd110, 8'd110, 8'd96,  8'd111, 8'd97,  8'd97,
        8'd98,  8'd98,  8'd99,  8'd99,  8'd100, 8'd100, 8'd102, 8'd101,
        8'd103, 8'd103, 8'd121, 8'd121, 8'd122, 8'd122, 8'd120, 8'd120,
        8'd154, 8'd153, 8'd152, 8'd152, 8'd137, 8'd137, 8'd138, 8'd138,
        8'd136, 8'd136, 8'd170, 8'd169, 8'd168, 8'd168, 8'd185, 8'd185,
        8'd184, 8'd184, 8'd217, 8'd217, 8'd216, 8'd218, 8'd201, 8'd201,
        8'd202, 8'd202, 8'd200, 8'd200, 8'd232, 8'd232, 8'd233, 8'd234,
        8'd224, 8'd224, 8'd239, 8'd239, 8'd238, 8'd238, 8'd237, 8'd237
    };

    localparam logic [7:0] DOT_PLAIN [0:2*RING_POSITIONS-1] = '{
        8'd236, 8'd236, 8'd231, 8'd231, 8'd230, 8'd230, 8'd229, 8'd229,
        8'd228, 8'd228, 8'd227, 8'd227, 8'd225, 8'd225, 8'd248, 8'd248,
        8'd250, 8'd250, 8'd249, 8'd249, 8'd24,  8'd24,  8'd25,  8'd25,
        8'd40,  8'd40,  8'd42,  8'd42,  8'd41,  8'd41,  8'd8,   8'd8,
        8'd9,   8'd9,   8'd56,  8'd56,  8'd58,  8'd58,  8'd57,  8'd57,
        8'd88,  8'd88,  8'd89,  8'd89,  8'd72,  8'd72,  8'd74,  8'd74,
        8'd104, 8'd104, 8'd105, 8'd105, 8'd107, 8'd107, 8'd108, 8'd108,
        8'd109, 8'd109, 8'd110, 8'd110, 8'd96,  8'd96,  8'd97,  8'd97,
        8'd98,  8'd98,  8'd99,  8'd99,  8'd100, 8'd100, 8'd102, 8'd102,
        8'd103, 8'd103, 8'd121, 8'd121, 8'd122, 8'd122, 8'd120, 8'd120,
        8'd154, 8'd154, 8'd152, 8'd152, 8'd137, 8'd137, 8'd138, 8'd138,
        8'd136, 8'd136, 8'd170, 8'd170, 8'd168, 8'd168, 8'd185, 8'd185,
        8'd184, 8'd184, 8'd217, 8'd217, 8'd216, 8'd216, 8'd201, 8'd201,
        8'd202, 8'd202, 8'd200, 8'd200, 8'd232, 8'd232, 8'd233, 8'd233,
        8'd224, 8'd224, 8'd239, 8'd239, 8'd238, 8'd238, 8'd237, 8'd237
    };

endpackage

@@ design/lrsl_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// lrsl_cfg_regs
// APB register file holding the tick mode and the seconds mode.
// ----------------------------------------------------------------------------
module lrsl_cfg_regs (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output lrsl_pkg::cfg_t cfg
);
    import lrsl_pkg::*;

    tick_sel_t  tick_mode_reg;
    dot_style_t dot_style_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // Register writes, word index in paddr[2]
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_mode_reg <= TICK_DIM;
            dot_style_reg <= SEC_LONG;
        end else if (wr_en) begin
            if (paddr[2] == REG_TICK_MODE) begin
                tick_mode_reg <= tick_sel_t'(pwdata[1:0]);
            end else begin
                dot_style_reg <= dot_style_t'(pwdata[2:0]);
            end
        end
    end

    // Read mux
    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_TICK_MODE) begin
            prdata[1:0] = tick_mode_reg;
        end else begin
            prdata[2:0] = dot_style_reg;
        end
    end

    assign cfg.tick_mode = tick_mode_reg;
    assign cfg.dot_style = dot_style_reg;

endmodule

@@ design/lrsl_seconds.sv @@
// ----------------------------------------------------------------------------
// lrsl_seconds
// Dot pair lookup and seconds brightness for one ring position.
// ----------------------------------------------------------------------------
module lrsl_seconds (
    input  lrsl_pkg::cfg_t cfg,
    input  logic [5:0]     cur,
    input  logic [5:0]     pos,
    output logic [7:0]     second_led,
    output logic [7:0]     pair_led,
    output logic [11:0]    second_level
);
    import lrsl_pkg::*;

    logic [6:0]  idx_lo;
    logic [6:0]  idx_hi;
    logic [6:0]  age_wide;
    logic [5:0]  age;
    logic [5:0]  tail_len;
    logic [7:0]  whole_mult;
    logic [1:0]  frac_shift;
    logic [12:0] whole_part;
    logic [8:0]  frac_num;
    logic [19:0] frac_prod;
    logic [12:0] drop;

    // Address pair from the table chosen by tick mode
    assign idx_lo = {pos, 1'b0};
    assign idx_hi = {pos, 1'b1};
    assign second_led = (cfg.tick_mode == TICK_TRACK) ? DOT_TRACK[idx_lo] : DOT_PLAIN[idx_lo];
    assign pair_led   = (cfg.tick_mode == TICK_TRACK) ? DOT_TRACK[idx_hi] : DOT_PLAIN[idx_hi];

    // Age of this position behind the current second, modulo the ring
    assign age_wide = (cur >= pos) ? ({1'b0, cur} - {1'b0, pos})
                                   : ({1'b0, cur} + 7'(RING_POSITIONS) - {1'b0, pos});
    assign age      = age_wide[5:0];

    // age*2048/L = age*(2048 div 15 scaled) + floor(age*rem/15)
    always_comb begin
        case (cfg.dot_style)
            SEC_SHORT: begin
                tail_len   = 6'd15;
                whole_mult = 8'd136;
                frac_shift = 2'd3;
            end
            SEC_MEDIUM: begin
                tail_len   = 6'd30;
                whole_mult = 8'd68;
                frac_shift = 2'd2;
            end
            default: begin
                tail_len   = 6'd60;
                whole_mult = 8'd34;
                frac_shift = 2'd1;
            end
        endcase
    end

    assign whole_part = 13'(age) * 13'(whole_mult);
    assign frac_num   = 9'({3'b000, age} << frac_shift);
    assign frac_prod  = 20'(frac_num) * 20'(DIV15_RECIP);
    assign drop       = whole_part + 13'(frac_prod[19:DIV15_SHIFT]);

    // Level by seconds mode
    always_comb begin
        case (cfg.dot_style)
            SEC_FILL:   second_level = (pos <= cur) ? LEVEL_FULL : LEVEL_DIM;
            SEC_SINGLE: second_level = (pos == cur) ? LEVEL_FULL : LEVEL_DIM;
            default: begin
                if (age >= tail_len) begin
                    second_level = LEVEL_OFF;
                end else begin
                    second_level = LEVEL_FULL - drop[11:0];
                end
            end
        endcase
    end

endmodule

@@ design/lrsl_tick.sv @@
// ----------------------------------------------------------------------------
// lrsl_tick
// Hour tick detection, tick LED lookup and tick brightness.
// ----------------------------------------------------------------------------
module lrsl_tick (
    input  lrsl_pkg::cfg_t cfg,
    input  logic [5:0]     pos,
    output logic [7:0]     tick_led,
    output logic [11:0]    tick_level,
    output logic           tick_valid
);
    import lrsl_pkg::*;

    logic [9:0] quot_prod;
    logic [3:0] tick_idx;
    logic [6:0] tick_pos;
    logic       on_tick;
    logic       shown;

    // pos / spacing by reciprocal; a tick sits where the product comes back exact
    assign quot_prod = 10'(pos) * 10'(TICK_RECIP);
    assign tick_idx  = quot_prod[TICK_RECIP_SHIFT +: 4];
    assign tick_pos  = 7'(tick_idx) * 7'(TICK_SPACING);
    assign on_tick   = (tick_pos == {1'b0, pos});
    assign shown     = (cfg.tick_mode == TICK_ON) || (cfg.tick_mode == TICK_DIM);

    always_comb begin
        tick_led   = 8'd0;
        tick_level = LEVEL_OFF;
        tick_valid = 1'b0;
        if (shown && on_tick) begin
            tick_led   = TICK_ADDR[tick_idx];
            tick_level = (cfg.tick_mode == TICK_ON) ? LEVEL_FULL : LEVEL_DIM;
            tick_valid = 1'b1;
        end
    end

endmodule

@@ design/led_ring_seconds_level.sv @@
// ----------------------------------------------------------------------------
// led_ring_seconds_level
// Seconds ring LED addresses and brightness for one queried position.
// ----------------------------------------------------------------------------
// Each query (current second, ring position) returns one result in the cycle
// after it is accepted; a new query is taken every cycle while s_tready is high, and
// the result register holds its transaction while m_tready is low, stalling s_tready.
// Inputs above 59 saturate to 59. Levels are linear, 2048 = full, 512 = dim. The user
// writes the registers tick_mode (0x0) and dot style (0x4) only while idle; not enforced.
// ----------------------------------------------------------------------------
module led_ring_seconds_level (
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // query stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // [5:0] shown second, [11:6] position, [15:12] zero
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,  // [7:0] second_led, [15:8] pair_led, [27:16] second_level,
                                  // [35:28] tick_led, [47:36] tick_level
    output logic        m_tuser   // [0] tick_valid
);
    import lrsl_pkg::*;

    cfg_t       cfg;
    res_t       res_next;
    res_t       res_reg;
    logic       valid_reg;
    logic       valid_next;
    logic [5:0] cur_sat;
    logic [5:0] pos_sat;
    logic       take;

    lrsl_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Saturate inputs to the last ring position
    assign cur_sat = (s_tdata[5:0]  > 6'(RING_LAST)) ? 6'(RING_LAST) : s_tdata[5:0];
    assign pos_sat = (s_tdata[11:6] > 6'(RING_LAST)) ? 6'(RING_LAST) : s_tdata[11:6];

    lrsl_seconds u_seconds (
        .cfg          (cfg),
        .cur          (cur_sat),
        .pos          (pos_sat),
        .second_led   (res_next.second_led),
        .pair_led     (res_next.pair_led),
        .second_level (res_next.second_level)
    );

    lrsl_tick u_tick (
        .cfg        (cfg),
        .pos        (pos_sat),
        .tick_led   (res_next.tick_led),
        .tick_level (res_next.tick_level),
        .tick_valid (res_next.tick_valid)
    );

    // Result register: load when empty or being drained
    assign s_tready   = !valid_reg || m_tready;
    assign take       = s_tvalid && s_tready;
    assign valid_next = take ? 1'b1 : (valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {res_reg.tick_level, res_reg.tick_led, res_reg.second_level,
                       res_reg.pair_led, res_reg.second_led};
    assign m_tuser  = res_reg.tick_valid;

    // Checks
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[27:16] <= LEVEL_FULL))
        else $error("second level above full scale");

    a_tick_level: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[47:36] == LEVEL_FULL || m_tdata[47:36] == LEVEL_DIM))
        else $error("driven tick has a bad level");

    a_tick_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[47:28] == 20'd0))
        else $error("tick fields set without a tick");

endmodule
